// ===== design/lphs_pkg.sv =====
// Package for the linear-probing hash set: transaction types, states and hash constants.
`timescale 1ns / 1ps

package lphs_pkg;

  // Table geometry and fill limit
  localparam int unsigned TABLE_SLOTS_DEF = 1024;
  localparam int unsigned FILL_NUM        = 3;
  localparam int unsigned FILL_DEN        = 4;

  // Multiplicative hash constants
  localparam logic [63:0] HASH_ADD = 64'd15485863;
  localparam logic [31:0] HASH_MUL = 32'd2654435761;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned COUNT_W = 10;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } lphs_op_t;

  // Input transaction
  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] key;
  } lphs_in_t;

  // Result transaction
  typedef struct packed {
    logic               found;
    logic               inserted;
    logic               full_res;
    logic [COUNT_W-1:0] key_count;
  } lphs_out_t;

  // Controller states, one-hot
  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_HASH  = 7'b0000100,
    S_MUL0  = 7'b0001000,
    S_MUL1  = 7'b0010000,
    S_MOD   = 7'b0100000,
    S_PROBE = 7'b1000000
  } lphs_state_t;

endpackage

// ===== design/linear_probe_hash_set.sv =====
// Linear-probing hash set of 64-bit keys held in a single-port-write slot memory.
// Sequence: with a power-of-two table, the hash state, then the probe loop over the slots, then the
//   result register; other table sizes add the multiply, 32-bit folds and a reciprocal step.
// Throughput: one transaction at a time; the probe loop reads one slot per cycle from the
//   memory port.
// Reset (synchronous, rst_n low) and every null_key write start a clearing pass that fills
//   each slot with the null key; no input is taken meanwhile.
`timescale 1ns / 1ps

module linear_probe_hash_set
  import lphs_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = TABLE_SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  lphs_in_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output lphs_out_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [KEY_W-1:0] cfg_data
);

  localparam int unsigned AW         = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam bit          IS_POW2    = ((64'd1 << AW) == 64'(TABLE_SLOTS));
  localparam int unsigned FILL_MAX   = TABLE_SLOTS * FILL_NUM / FILL_DEN;
  localparam int unsigned FOLD_STEPS = 3;
  localparam int unsigned MOD_STEPS  = FOLD_STEPS + 3;
  localparam int unsigned SW         = $clog2(MOD_STEPS);
  localparam logic [AW-1:0]   LAST_SLOT = AW'(TABLE_SLOTS - 1);
  localparam logic [AW:0]     ONE_T     = (AW + 1)'(TABLE_SLOTS);
  localparam logic [AW-1:0]   R32       = AW'((64'd1 << 32) % 64'(TABLE_SLOTS));
  localparam logic [31:0]     RECIP     = 32'((64'd1 << 32) / 64'(TABLE_SLOTS));
  localparam logic [SW-1:0]   QUO_STEP  = SW'(FOLD_STEPS);
  localparam logic [SW-1:0]   REM_STEP  = SW'(FOLD_STEPS + 1);
  localparam logic [SW-1:0]   LAST_STEP = SW'(FOLD_STEPS + 2);

  // Slot memory
  logic [KEY_W-1:0] mem [TABLE_SLOTS];
  logic [KEY_W-1:0] rd_data_r;
  logic [AW-1:0]    rd_addr;
  logic             mem_we;
  logic [AW-1:0]    wr_addr;
  logic [KEY_W-1:0] wr_data;

  // Control state
  lphs_state_t        state_r, state_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic [COUNT_W-1:0] fill_r, fill_nxt;
  logic [KEY_W-1:0]   null_key_r, null_key_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Datapath state
  logic               op_r, op_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [AW-1:0]      cnt_r, cnt_nxt;
  logic [KEY_W-1:0]   sum_r, sum_nxt;
  logic [KEY_W-1:0]   prod_r, prod_nxt;
  logic [31:0]        quo_r, quo_nxt;
  logic [AW:0]        rem_r, rem_nxt;
  logic [SW-1:0]      step_r, step_nxt;
  lphs_out_t          out_data_r, out_data_nxt;

  // Combinational helpers
  logic               in_acc, cfg_acc, out_free;
  logic               fin;
  lphs_out_t          res;
  logic [AW-1:0]      sum_lo;
  logic [AW-1:0]      home_lo;
  logic [KEY_W-1:0]   mul_lo;
  logic [31:0]        mul_hi;
  logic [AW-1:0]      mod_slot;
  logic               room;
  logic [AW-1:0]      idx_inc;

  assign in_acc   = in_valid && !in_stall;
  assign cfg_acc  = cfg_valid && cfg_ready;
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Home slot for a power-of-two table: only the low bits of the product matter
  assign sum_lo  = key_r[AW-1:0] + HASH_ADD[AW-1:0];
  assign home_lo = sum_lo * HASH_MUL[AW-1:0];

  // Full 64-bit product in two halves
  assign mul_lo = 64'(sum_r[31:0]) * 64'(HASH_MUL);
  assign mul_hi = sum_r[63:32] * HASH_MUL;

  // Remainder after the reciprocal quotient is below twice the table size
  assign mod_slot = (rem_r >= ONE_T) ? AW'(rem_r - ONE_T) : rem_r[AW-1:0];

  assign room    = (32'(fill_r) + 32'd1) <= FILL_MAX;
  assign idx_inc = (idx_r == LAST_SLOT) ? '0 : idx_r + AW'(1);

  // Next-state logic
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    fill_nxt      = fill_r;
    null_key_nxt  = null_key_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    prod_nxt      = prod_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    rd_addr       = idx_r;
    mem_we        = 1'b0;
    wr_addr       = idx_r;
    wr_data       = key_r;
    fin           = 1'b0;
    res           = '0;
    res.key_count = fill_r;

    unique case (state_r)
      S_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = clr_r;
        wr_data = null_key_r;
        if (clr_r == LAST_SLOT) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_data.op;
          key_nxt   = in_data.key;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (key_r == null_key_r) begin
          // null key is never a member
          fin = 1'b1;
        end else if (IS_POW2) begin
          rd_addr   = home_lo;
          idx_nxt   = home_lo;
          cnt_nxt   = '0;
          state_nxt = S_PROBE;
        end else begin
          sum_nxt   = key_r + HASH_ADD;
          state_nxt = S_MUL0;
        end
      end
      S_MUL0: begin
        prod_nxt  = mul_lo;
        step_nxt  = '0;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        prod_nxt  = prod_r + {mul_hi, 32'd0};
        state_nxt = S_MOD;
      end
      S_MOD: begin
        step_nxt = step_r + SW'(1);
        unique case (step_r)
          QUO_STEP: begin
            // quotient estimate, low by at most one
            quo_nxt = 32'((64'(prod_r[31:0]) * 64'(RECIP)) >> 32);
          end
          REM_STEP: begin
            rem_nxt = (AW + 1)'(prod_r[31:0] - quo_r * 32'(TABLE_SLOTS));
          end
          LAST_STEP: begin
            rd_addr   = mod_slot;
            idx_nxt   = mod_slot;
            cnt_nxt   = '0;
            state_nxt = S_PROBE;
          end
          default: begin
            // fold the upper half back in, weighted by 2^32 mod table size
            prod_nxt = 64'((32 + AW)'(prod_r[63:32]) * (32 + AW)'(R32))
                       + 64'(prod_r[31:0]);
          end
        endcase
      end
      S_PROBE: begin
        if (rd_data_r == key_r) begin
          fin       = 1'b1;
          res.found = 1'b1;
        end else if (rd_data_r == null_key_r) begin
          fin = 1'b1;
          if (op_r == OP_INSERT) begin
            if (room) begin
              res.inserted  = 1'b1;
              res.key_count = fill_r + COUNT_W'(1);
              if (out_free) begin
                mem_we   = 1'b1;
                fill_nxt = fill_r + COUNT_W'(1);
              end
            end else begin
              res.full_res = 1'b1;
            end
          end
        end else if (cnt_r == LAST_SLOT) begin
          // whole table walked without a hit or a free slot
          fin          = 1'b1;
          res.full_res = (op_r == OP_INSERT);
        end else begin
          idx_nxt = idx_inc;
          rd_addr = idx_inc;
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        clr_nxt   = '0;
      end
    endcase

    // Deliver into the result register once it is free
    if (fin && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
      state_nxt     = S_IDLE;
    end

    // A null key write restarts the clearing pass
    if (cfg_acc) begin
      null_key_nxt = cfg_data;
      fill_nxt     = '0;
      clr_nxt      = '0;
      state_nxt    = S_CLEAR;
    end
  end

  // Slot memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      fill_r      <= '0;
      null_key_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      fill_r      <= fill_nxt;
      null_key_r  <= null_key_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    sum_r      <= sum_nxt;
    prod_r     <= prod_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    step_r     <= step_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== sim/tb_linear_probe_hash_set.sv =====
// Self-checking testbench for the linear-probing hash set: scoreboard, drivers and phases.
`timescale 1ns / 1ps

module tb_linear_probe_hash_set;
  import lphs_pkg::*;

  localparam int unsigned SLOTS      = 1024;
  localparam int unsigned LIMIT_NUM  = 3;
  localparam int unsigned LIMIT_DEN  = 4;
  localparam logic [63:0] H_OFFSET   = 64'd15485863;
  localparam logic [63:0] H_FACTOR   = 64'd2654435761;
  localparam int unsigned MAX_CYCLES = 4000000;
  localparam int unsigned DRAIN_WAIT = 16;

  // Hash-set mirror: slot contents, fill count and the queue of awaited results
  class hash_set_scoreboard;
    logic [63:0] slot_mirror [SLOTS];
    logic [63:0] empty_key;
    int unsigned fill_count;
    lphs_out_t   awaited_q[$];
    int unsigned errors;

    function new();
      errors = 0;
      wipe('0);
    endfunction

    function void wipe(logic [63:0] nk);
      empty_key = nk;
      foreach (slot_mirror[i]) slot_mirror[i] = nk;
      fill_count = 0;
    endfunction

    function int unsigned home(logic [63:0] key);
      logic [63:0] h;
      h = (key + H_OFFSET) * H_FACTOR;
      return 32'(h % 64'(SLOTS));
    endfunction

    // Walk the probe chain for one accepted transaction and queue the outcome
    function void note_request(lphs_op_t op, logic [63:0] key);
      lphs_out_t   res;
      int unsigned idx;
      int unsigned n;
      bit          hit;
      bit          gap;
      res = '0;
      if (key != empty_key) begin
        idx = home(key);
        hit = 1'b0;
        gap = 1'b0;
        for (n = 0; n < SLOTS && !hit && !gap; n++) begin
          if (slot_mirror[idx] == key) hit = 1'b1;
          else if (slot_mirror[idx] == empty_key) gap = 1'b1;
          else idx = (idx + 1) % SLOTS;
        end
        if (hit) begin
          res.found = 1'b1;
        end else if (op == OP_INSERT) begin
          if (gap && SLOTS * LIMIT_NUM >= (fill_count + 1) * LIMIT_DEN) begin
            slot_mirror[idx] = key;
            fill_count = (fill_count + 1) & 32'h3FF;
            res.inserted = 1'b1;
          end else begin
            res.full_res = 1'b1;
          end
        end
      end
      res.key_count = fill_count[COUNT_W-1:0];
      awaited_q.push_back(res);
    endfunction

    function void check_result(lphs_out_t got);
      lphs_out_t exp;
      if (awaited_q.size() == 0) begin
        $error("result with nothing awaited: %h", got);
        errors++;
        return;
      end
      exp = awaited_q.pop_front();
      if (got.found !== exp.found) begin
        $error("found: expected %0d, got %0d", exp.found, got.found);
        errors++;
      end
      if (got.inserted !== exp.inserted) begin
        $error("inserted: expected %0d, got %0d", exp.inserted, got.inserted);
        errors++;
      end
      if (got.full_res !== exp.full_res) begin
        $error("full_res: expected %0d, got %0d", exp.full_res, got.full_res);
        errors++;
      end
      if (got.key_count !== exp.key_count) begin
        $error("key_count: expected %0d, got %0d", exp.key_count, got.key_count);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  lphs_in_t         in_data;
  logic             out_valid;
  logic             out_stall;
  lphs_out_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [KEY_W-1:0] cfg_data;

  hash_set_scoreboard sb = new();
  logic [63:0]        key_pool[$];
  int unsigned        sent_count;
  bit                 burst_mode;

  linear_probe_hash_set #(
    .TABLE_SLOTS(SLOTS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offer one transaction after a random gap; returns once it has been taken
  task automatic send_request(lphs_op_t op, logic [63:0] key);
    int unsigned gap;
    int unsigned r;
    if (sent_count % 64 == 0) burst_mode = ($urandom_range(0, 3) == 0);
    r = $urandom_range(0, 99);
    if (burst_mode || r < 60) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= '{op: op, key: key};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(op, key);
    if (op == OP_INSERT && key != sb.empty_key) key_pool.push_back(key);
    sent_count++;
  endtask

  // Random transaction; fresh_pct steers how many keys are new rather than reused
  task automatic send_random(int unsigned insert_pct, int unsigned fresh_pct);
    lphs_op_t    op;
    logic [63:0] key;
    int unsigned r;
    op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_LOOKUP;
    r = $urandom_range(0, 99);
    if (r < fresh_pct || key_pool.size() == 0) begin
      key = {$urandom, $urandom};
    end else begin
      r = $urandom_range(0, 99);
      key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      if (r < 35) key = key + 64'(SLOTS) * $urandom_range(1, 3);  // same home slot
      else if (r < 50) key = sb.empty_key;
      else if (r < 62) key = 64'($urandom_range(0, 15));
      else if (r < 70) begin
        case ($urandom_range(0, 3))
          0: key = '0;
          1: key = '1;
          2: key = 64'h8000_0000_0000_0000;
          default: key = 64'h7FFF_FFFF_FFFF_FFFF;
        endcase
      end
    end
    send_request(op, key);
  endtask

  // Let the block go idle, then load a new null key (clears the table)
  task automatic write_null_key(logic [63:0] nk);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.awaited_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= nk;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.wipe(nk);
    key_pool.delete();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stalls, one long hold-off, and checking of every transaction
  initial begin : result_side
    int unsigned stall_left;
    int unsigned results_seen;
    int unsigned cyc;
    bit          quiet;
    bit          held_off;
    out_stall    = 1'b0;
    stall_left   = 0;
    results_seen = 0;
    cyc          = 0;
    quiet        = 1'b0;
    held_off     = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        sb.check_result(out_data);
        results_seen++;
      end
      @(negedge clk);
      cyc++;
      if (cyc % 256 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (!held_off && results_seen >= 60) begin
        held_off   = 1'b1;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3: begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(0, 2);
          end
          4: begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(10, 40);
          end
          default: out_stall <= 1'b0;
        endcase
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < MAX_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("linear_probe_hash_set regression: fail");
    $finish;
  end

  initial begin : stimulus
    logic [63:0] base;
    logic [63:0] wrap_key;
    int unsigned i;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    sent_count = 0;
    burst_mode = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: null key handling, present/absent keys, collision chains, wrap-around
    base = 64'h0123_4567_89AB_CDEF;
    wrap_key = '0;
    while (sb.home(wrap_key) != SLOTS - 1) wrap_key++;
    send_request(OP_LOOKUP, '0);
    send_request(OP_INSERT, '0);
    send_request(OP_LOOKUP, '1);
    send_request(OP_INSERT, '1);
    send_request(OP_LOOKUP, '1);
    send_request(OP_INSERT, '1);
    send_request(OP_INSERT, 64'd1);
    send_request(OP_INSERT, 64'h5555_5555_5555_5555);
    send_request(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(OP_INSERT, base);
    send_request(OP_INSERT, base + 64'(SLOTS));
    send_request(OP_INSERT, base + 64'(2 * SLOTS));
    send_request(OP_LOOKUP, base + 64'(3 * SLOTS));
    send_request(OP_LOOKUP, base + 64'(2 * SLOTS));
    send_request(OP_LOOKUP, base + 64'(SLOTS));
    send_request(OP_INSERT, 64'h8000_0000_0000_0000);
    send_request(OP_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF);
    send_request(OP_INSERT, wrap_key);
    send_request(OP_INSERT, wrap_key + 64'(SLOTS));
    send_request(OP_LOOKUP, wrap_key + 64'(2 * SLOTS));
    send_request(OP_LOOKUP, wrap_key + 64'(SLOTS));

    // All-ones as null key: zero becomes an ordinary key
    write_null_key('1);
    send_request(OP_INSERT, '1);
    send_request(OP_LOOKUP, '1);
    send_request(OP_INSERT, '0);
    send_request(OP_LOOKUP, '0);
    for (i = 0; i < 250; i++) send_random(55, 40);

    // Random null key: fill to the three-quarter limit, then keep pushing
    write_null_key({$urandom, $urandom});
    while (sb.fill_count < SLOTS * LIMIT_NUM / LIMIT_DEN) send_random(85, 75);
    for (i = 0; i < 150; i++) send_random(60, 40);

    // Back to zero as null key
    write_null_key('0);
    for (i = 0; i < 250; i++) send_random(50, 35);

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.awaited_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("linear_probe_hash_set regression: pass");
    end else begin
      $display("linear_probe_hash_set regression: fail");
    end
    $finish;
  end

endmodule
